// ----- design/itp_pkg.sv -----
`timescale 1ns / 1ps

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CHAR_W      = 8;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

   localparam logic [1:0] PREC_NONE = 2'd0;
   localparam logic [1:0] PREC_LOW  = 2'd1;
   localparam logic [1:0] PREC_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_UNMATCHED_CLOSE,
      ERR_UNMATCHED_OPEN,
      ERR_OVERFLOW
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_POP_CHK,
      S_PUSH,
      S_AFTER,
      S_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      M_OP,
      M_CLOSE,
      M_FLUSH
   } pop_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      err_type           error_code;
      logic              run_last;
      logic              expr_done;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } out_load_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } stack_ctrl_type;

   function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
      logic [1:0] p;
      p = PREC_NONE;
      if (c == CH_STAR || c == CH_SLASH) begin
         p = PREC_HIGH;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         p = PREC_LOW;
      end
      return p;
   endfunction

   function automatic logic is_operand(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

// ----- design/itp_req_if.sv -----
`timescale 1ns / 1ps

interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_expr;

   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ----- design/itp_rsp_if.sv -----
`timescale 1ns / 1ps

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic [1:0] error_code;
   logic       run_last;
   logic       expr_done;

   modport source (output valid, output out_char, output char_valid, output error_code,
                   output run_last, output expr_done, input ready);
   modport sink (input valid, input out_char, input char_valid, input error_code,
                 input run_last, input expr_done, output ready);
endinterface

// ----- design/itp_stack_ram.sv -----
`timescale 1ns / 1ps

module itp_stack_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] stack_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/itp_out_reg.sv -----
`timescale 1ns / 1ps

module itp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  itp_pkg::out_load_type out_load,
   output logic                 out_free,
   itp_rsp_if.source            rsp_chan
);
   import itp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_load.load) begin
         valid_in = 1'b1;
         data_in  = out_load.data;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_char   = data_ff.out_char;
   assign rsp_chan.char_valid = data_ff.char_valid;
   assign rsp_chan.error_code = data_ff.error_code;
   assign rsp_chan.run_last   = data_ff.run_last;
   assign rsp_chan.expr_done  = data_ff.expr_done;

endmodule

// ----- design/itp_sequencer.sv -----
`timescale 1ns / 1ps

module itp_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   itp_req_if.sink                       req_chan,
   input  logic                          out_free,
   input  logic [itp_pkg::CHAR_W-1:0]    rd_data,
   output itp_pkg::stack_ctrl_type       stack_ctrl,
   output itp_pkg::out_load_type         out_load
);
   import itp_pkg::*;

   seq_state_type     state_ff, state_in;
   pop_mode_type      mode_ff, mode_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [1:0]        prec_ff, prec_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  open_ff, open_in;
   err_type           error_ff, error_in;
   logic [CHAR_W-1:0] cand_ff, cand_in;
   logic              cand_valid_ff, cand_valid_in;

   logic              accept;
   logic [CHAR_W-1:0] c;
   logic [1:0]        in_prec;
   logic              in_op, in_open, in_close, in_operand;
   logic              full, count_nz, more;
   logic [CNT_W-1:0]  cnt_dec;
   logic              top_open, pop_want, emit_want, chk_stall;
   logic              acc_ovf, acc_unm;
   logic [CNT_W-1:0]  acc_open;
   err_type           acc_err;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = (state_ff == S_IDLE) && req_chan.valid;
   assign c              = req_chan.in_char;
   assign in_prec        = prec_of(c);
   assign in_op          = (in_prec != PREC_NONE);
   assign in_open        = (c == CH_LPAREN);
   assign in_close       = (c == CH_RPAREN);
   assign in_operand     = is_operand(c);

   assign full     = (count_ff == DEPTH_CNT);
   assign count_nz = (count_ff != '0);
   assign cnt_dec  = count_ff - 1'b1;
   assign more     = (cnt_dec != '0);

   // the top of stack reaches rd_data in the cycle after the last count change
   assign top_open  = (rd_data == CH_LPAREN);
   assign pop_want  = (mode_ff == M_OP) ? (prec_of(rd_data) >= prec_ff) : 1'b1;
   assign emit_want = pop_want && !top_open;
   assign chk_stall = emit_want && cand_valid_ff && !out_free;

   // the error of the whole transaction is settled up front so that every
   // result of it carries the same code
   assign acc_ovf  = (in_op && full && (prec_of(rd_data) < in_prec)) || (in_open && full);
   assign acc_unm  = in_close && (open_ff == '0);
   assign acc_open = (in_open && !full) ? open_ff + 1'b1 :
                     (in_close && open_ff != '0) ? open_ff - 1'b1 : open_ff;

   always_comb begin
      priority if (error_ff != ERR_NONE) begin
         acc_err = error_ff;
      end else if (acc_ovf) begin
         acc_err = ERR_OVERFLOW;
      end else if (acc_unm) begin
         acc_err = ERR_UNMATCHED_CLOSE;
      end else if (req_chan.end_of_expr && acc_open != '0) begin
         acc_err = ERR_UNMATCHED_OPEN;
      end else begin
         acc_err = ERR_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (in_operand) begin
                  state_in = S_AFTER;
               end else if (in_op) begin
                  state_in = count_nz ? S_POP_RD : S_PUSH;
               end else if (in_open) begin
                  state_in = S_PUSH;
               end else if (in_close) begin
                  state_in = count_nz ? S_POP_RD : S_AFTER;
               end else begin
                  state_in = S_AFTER;
               end
            end
         end
         S_POP_RD: begin
            state_in = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (!chk_stall) begin
               unique case (mode_ff)
                  M_OP:    state_in = (pop_want && more) ? S_POP_RD : S_PUSH;
                  M_CLOSE: state_in = (!top_open && more) ? S_POP_RD : S_AFTER;
                  M_FLUSH: state_in = more ? S_POP_RD : S_FINISH;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_PUSH: begin
            state_in = S_AFTER;
         end
         S_AFTER: begin
            state_in = (last_ff && count_nz) ? S_POP_RD : S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      prec_in       = prec_ff;
      count_in      = count_ff;
      open_in       = open_ff;
      error_in      = error_ff;
      cand_in       = cand_ff;
      cand_valid_in = cand_valid_ff;
      out_load      = '0;

      stack_ctrl.wr_en   = (state_ff == S_PUSH) && !full;
      stack_ctrl.wr_addr = count_ff[ADDR_W-1:0];
      stack_ctrl.wr_data = char_ff;
      stack_ctrl.rd_addr = count_nz ? cnt_dec[ADDR_W-1:0] : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in  = c;
               last_in  = req_chan.end_of_expr;
               prec_in  = in_prec;
               mode_in  = in_close ? M_CLOSE : M_OP;
               open_in  = acc_open;
               error_in = acc_err;
               if (in_operand) begin
                  cand_in       = c;
                  cand_valid_in = 1'b1;
               end
            end
         end
         S_POP_CHK: begin
            if (!chk_stall && pop_want) begin
               count_in = cnt_dec;
               if (emit_want) begin
                  // hold the newest character; release the older one as non-final
                  if (cand_valid_ff) begin
                     out_load.load            = 1'b1;
                     out_load.data.out_char   = cand_ff;
                     out_load.data.char_valid = 1'b1;
                     out_load.data.error_code = error_ff;
                  end
                  cand_in       = rd_data;
                  cand_valid_in = 1'b1;
               end
            end
         end
         S_PUSH: begin
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end
         S_AFTER: begin
            // drain the whole stack after the last character
            if (last_ff && count_nz) begin
               mode_in = M_FLUSH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load.load            = 1'b1;
               out_load.data.out_char   = cand_valid_ff ? cand_ff : '0;
               out_load.data.char_valid = cand_valid_ff;
               out_load.data.error_code = error_ff;
               out_load.data.run_last   = 1'b1;
               out_load.data.expr_done  = last_ff;
               cand_valid_in            = 1'b0;
               if (last_ff) begin
                  error_in = ERR_NONE;
                  open_in  = '0;
                  count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         open_ff       <= '0;
         error_ff      <= ERR_NONE;
         cand_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         open_ff       <= open_in;
         error_ff      <= error_in;
         cand_valid_ff <= cand_valid_in;
      end
      mode_ff <= mode_in;
      char_ff <= char_in;
      last_ff <= last_in;
      prec_ff <= prec_in;
      cand_ff <= cand_in;
   end

endmodule

// ----- design/infix_to_postfix_converter.sv -----
`timescale 1ns / 1ps

// Infix to postfix converter with an operator stack.
// req_chan carries one character of an infix expression per transaction,
// with end_of_expr set on the last character. rsp_chan returns the postfix
// characters in order; every request yields at least one response, the last
// one marked run_last, and on the final request of an expression expr_done.
// A response with char_valid low carries no character. error_code shows the
// first error of the expression in every response of the request.
// Sequence: once a request is accepted, ready stays low while the sequencer
// takes every stack entry examined or popped (one RAM read and one compare
// per entry), then a push if one is due; ready returns when it goes idle.
// For a plain operand the response shows on rsp_chan in the same cycle that
// ready returns. The stack lives in a single-port-write RAM with registered
// read, which is why each pop needs a read step and a compare step.
// A one-entry output register lets a new request be accepted while the final
// response still waits; a stalled receiver holds the sequencer at the next
// emitted character until the register drains.
// Reset (synchronous) empties the stack and clears the error state; the stack
// RAM contents are not cleared and no clearing pass is needed.
module infix_to_postfix_converter (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req_chan,
   itp_rsp_if.source rsp_chan
);
   import itp_pkg::*;

   stack_ctrl_type    stack_ctrl;
   out_load_type      out_load;
   logic              out_free;
   logic [CHAR_W-1:0] rd_data;

   itp_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .out_free   (out_free),
      .rd_data    (rd_data),
      .stack_ctrl (stack_ctrl),
      .out_load   (out_load)
   );

   itp_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (CHAR_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_ctrl.wr_en),
      .wr_addr (stack_ctrl.wr_addr),
      .wr_data (stack_ctrl.wr_data),
      .rd_addr (stack_ctrl.rd_addr),
      .rd_data (rd_data)
   );

   itp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .out_load (out_load),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- bench/infix_to_postfix_converter_test.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;
   import itp_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoe;
   } infix_char_type;

   logic clock = 1'b0;
   logic reset;

   itp_req_if req_bus ();
   itp_rsp_if rsp_bus ();

   infix_to_postfix_converter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and prediction state
   infix_char_type char_q[$];
   rsp_type        postfix_q[$];
   int             item_total;
   int             sent_total;
   int             accepted_cnt;
   int             fail_cnt;

   logic [7:0]  op_stack[STACK_DEPTH];
   int          depth_cnt;
   err_type     expr_err;

   // quiet stretches with no idling on either side
   logic        quiet;
   int          phase_cnt;

   always @(posedge clock) begin
      if (reset) begin
         quiet     <= 1'b0;
         phase_cnt <= 0;
      end else begin
         phase_cnt <= (phase_cnt == 63) ? 0 : phase_cnt + 1;
         if (phase_cnt == 63) begin
            quiet <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic int rank_of(logic [7:0] c);
      case (c)
         CH_STAR, CH_SLASH: return 2;
         CH_PLUS, CH_MINUS: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic bit passes_through(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // keep the first error of the expression
   task automatic note_error(input err_type code);
      if (expr_err == ERR_NONE) begin
         expr_err = code;
      end
   endtask

   task automatic push_op(input logic [7:0] c);
      if (depth_cnt >= STACK_DEPTH) begin
         note_error(ERR_OVERFLOW);
      end else begin
         op_stack[depth_cnt] = c;
         depth_cnt++;
      end
   endtask

   task automatic convert_char(input logic [7:0] ch, input logic eoe);
      logic [7:0] emitted[$];
      logic [7:0] top;
      bit         matched;
      rsp_type    r;
      int         n;
      if (passes_through(ch)) begin
         emitted.push_back(ch);
      end else if (rank_of(ch) != 0) begin
         while (depth_cnt > 0 && rank_of(op_stack[depth_cnt-1]) >= rank_of(ch)) begin
            depth_cnt--;
            emitted.push_back(op_stack[depth_cnt]);
         end
         push_op(ch);
      end else if (ch == CH_LPAREN) begin
         push_op(ch);
      end else if (ch == CH_RPAREN) begin
         matched = 1'b0;
         while (depth_cnt > 0 && !matched) begin
            depth_cnt--;
            top = op_stack[depth_cnt];
            if (top == CH_LPAREN) begin
               matched = 1'b1;
            end else begin
               emitted.push_back(top);
            end
         end
         if (!matched) begin
            note_error(ERR_UNMATCHED_CLOSE);
         end
      end
      if (eoe) begin
         // flush; a leftover open paren is dropped and flagged
         while (depth_cnt > 0) begin
            depth_cnt--;
            top = op_stack[depth_cnt];
            if (top == CH_LPAREN) begin
               note_error(ERR_UNMATCHED_OPEN);
            end else begin
               emitted.push_back(top);
            end
         end
      end
      n = emitted.size();
      if (n == 0) begin
         r = '0;
         r.error_code = expr_err;
         r.run_last   = 1'b1;
         r.expr_done  = eoe;
         postfix_q.push_back(r);
      end
      for (int i = 0; i < n; i++) begin
         r.out_char   = emitted[i];
         r.char_valid = 1'b1;
         r.error_code = expr_err;
         r.run_last   = (i == n - 1);
         r.expr_done  = eoe && (i == n - 1);
         postfix_q.push_back(r);
      end
      if (eoe) begin
         expr_err = ERR_NONE;
      end
   endtask

   task automatic add_char(input logic [7:0] ch, input logic eoe);
      char_q.push_back('{ch: ch, eoe: eoe});
      item_total++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] rand_operand();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range("0", "9"));
         1: return 8'($urandom_range("A", "Z"));
         default: return 8'($urandom_range("a", "z"));
      endcase
   endfunction

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] rand_junk();
      case ($urandom_range(0, 3))
         0: return CH_LPAREN;
         1: return CH_RPAREN;
         2: return rand_operator();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_expr(input bit deep, input bit broken);
      logic [7:0] text_q[$];
      int         len;
      int         depth;
      int         k;
      int         opens;
      int         closes;
      bit         want_operand;
      if (deep) begin
         // nest deep enough to reach, and sometimes pass, the stack limit
         opens = $urandom_range(24, 40);
         for (int i = 0; i < opens; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               text_q.push_back(rand_operand());
               text_q.push_back(rand_operator());
            end
            text_q.push_back(CH_LPAREN);
         end
         text_q.push_back(rand_operand());
         closes = $urandom_range(0, opens + 1);
         for (int i = 0; i < closes; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               text_q.push_back(rand_operator());
               text_q.push_back(rand_operand());
            end
            text_q.push_back(CH_RPAREN);
         end
      end else begin
         len = $urandom_range(1, 12);
         depth = 0;
         k = 0;
         want_operand = 1'b1;
         while (want_operand || k < len) begin
            if (want_operand) begin
               if (depth < 6 && $urandom_range(0, 3) == 0) begin
                  text_q.push_back(CH_LPAREN);
                  depth++;
               end else begin
                  text_q.push_back(rand_operand());
                  want_operand = 1'b0;
               end
            end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
               text_q.push_back(CH_RPAREN);
               depth--;
            end else begin
               text_q.push_back(rand_operator());
               want_operand = 1'b1;
            end
            k++;
         end
         while (depth > 0) begin
            text_q.push_back(CH_RPAREN);
            depth--;
         end
      end
      for (int i = 0; i < text_q.size(); i++) begin
         if ($urandom_range(0, 14) == 0) begin
            add_char(8'($urandom_range(0, 255)), 1'b0);
         end
         if (broken && $urandom_range(0, 4) == 0) begin
            text_q[i] = rand_junk();
         end
         add_char(text_q[i], i == text_q.size() - 1);
      end
   endtask

   // request driver
   infix_char_type next_item;
   int             hold_cnt;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.in_char     <= '0;
         req_bus.end_of_expr <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            hold_cnt = pick_gap();
         end
         // hold the transaction until it is taken
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (hold_cnt > 0) begin
               hold_cnt--;
               req_bus.valid <= 1'b0;
            end else if (char_q.size() > 0) begin
               next_item = char_q.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.in_char     <= next_item.ch;
               req_bus.end_of_expr <= next_item.eoe;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and predictor
   rsp_type want;
   int      stall_cnt;

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (postfix_q.size() == 0) begin
               $error("unexpected response: out_char %0h char_valid %0b",
                      rsp_bus.out_char, rsp_bus.char_valid);
               fail_cnt++;
            end else begin
               want = postfix_q.pop_front();
               compare_field("out_char", want.out_char, rsp_bus.out_char);
               compare_field("char_valid", 8'(want.char_valid), 8'(rsp_bus.char_valid));
               compare_field("error_code", 8'(want.error_code), 8'(rsp_bus.error_code));
               compare_field("run_last", 8'(want.run_last), 8'(rsp_bus.run_last));
               compare_field("expr_done", 8'(want.expr_done), 8'(rsp_bus.expr_done));
            end
            stall_cnt = pick_gap();
         end
         if (req_bus.valid && req_bus.ready) begin
            convert_char(req_bus.in_char, req_bus.end_of_expr);
            accepted_cnt++;
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_char     = '0;
      req_bus.end_of_expr = 1'b0;
      rsp_bus.ready       = 1'b0;
      item_total   = 0;
      accepted_cnt = 0;
      fail_cnt     = 0;
      depth_cnt    = 0;
      expr_err     = ERR_NONE;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         op_stack[i] = '0;
      end

      // directed: code extremes, every operator, grouping and the unmatched-paren error cases
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      add_text("0*Z-a/9+z");
      add_text("a)");
      add_text("(a");
      add_text(")(");
      add_text("(A+z)*9");
      add_char(8'hFF, 1'b1);

      while (item_total < 270) begin
         build_expr($urandom_range(0, 14) == 0, $urandom_range(0, 5) == 0);
      end
      sent_total = char_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_cnt == sent_total);
      wait (postfix_q.size() == 0);
      repeat (200) @(posedge clock);
      if (postfix_q.size() != 0) begin
         $error("%0d expected responses never arrived", postfix_q.size());
         fail_cnt++;
      end
      if (fail_cnt == 0) begin
         $display("PASS infix_to_postfix_converter");
      end else begin
         $display("FAIL infix_to_postfix_converter");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL infix_to_postfix_converter");
      $finish;
   end

endmodule
